// ----- rtl/kpi_pkg.sv -----
// Shared types, codes and constants for the keyframe path interpolator.
// Used by kpi_front, kpi_back, keyframe_path_interpolator and the testbench; depends on nothing.
package kpi_pkg;

   localparam int MaxKeysDefault   = 16;
   localparam int SineDepthDefault = 256;
   localparam int QueueDepth       = 2;
   localparam int CoordCount       = 6;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_REWIND = 2'd2;

   localparam logic [1:0] STATUS_MOVED     = 2'd0;
   localparam logic [1:0] STATUS_UNCHANGED = 2'd1;
   localparam logic [1:0] STATUS_STORED    = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic [2:0] EASE_SINE_IN     = 3'd1;
   localparam logic [2:0] EASE_SINE_OUT    = 3'd2;
   localparam logic [2:0] EASE_SINE_INOUT  = 3'd3;
   localparam logic [2:0] EASE_CUBIC_IN    = 3'd4;
   localparam logic [2:0] EASE_CUBIC_OUT   = 3'd5;
   localparam logic [2:0] EASE_CUBIC_INOUT = 3'd6;

   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [15:0] HALF_Q16 = 16'd32768;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_TICK,
      KIND_REWIND,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic [23:0]                 time_step;
      logic [31:0]                 key_time;
      logic [CoordCount-1:0][31:0] coord;
      logic [2:0]                  easing;
   } item_type;

   typedef struct packed {
      logic [2:0]                  mode;
      logic [31:0]                 key_time;
      logic [CoordCount-1:0][31:0] coord;
   } key_rec_type;

   // Quarter-wave sine entry from an angle in Q30, by a seven-term Taylor series.
   function automatic logic [16:0] sine_from_angle(input logic [63:0] a);
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [66:0] sum;
      logic [66:0]        r;
      a2   = (a * a) >> 30;
      term = a;
      sum  = $signed({3'b000, a});
      term = ((term * a2) >> 30) / 64'd6;
      sum  = sum - $signed({3'b000, term});
      term = ((term * a2) >> 30) / 64'd20;
      sum  = sum + $signed({3'b000, term});
      term = ((term * a2) >> 30) / 64'd42;
      sum  = sum - $signed({3'b000, term});
      term = ((term * a2) >> 30) / 64'd72;
      sum  = sum + $signed({3'b000, term});
      term = ((term * a2) >> 30) / 64'd110;
      sum  = sum - $signed({3'b000, term});
      term = ((term * a2) >> 30) / 64'd156;
      sum  = sum + $signed({3'b000, term});
      if (sum < 0) begin
         sum = '0;
      end
      r = ($unsigned(sum) + 67'd8192) >> 14;
      if (r > 67'd65536) begin
         r = 67'd65536;
      end
      return r[16:0];
   endfunction

endpackage

// ----- rtl/kpi_front.sv -----
// Front end: accepts request transfers, classifies the opcode and queues items.
// Depends on kpi_pkg.
module kpi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [255:0]      req_tdata,
   input  logic [1:0]        req_tuser,
   output logic              item_valid,
   input  logic              item_ready,
   output kpi_pkg::item_type item
);
   import kpi_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   item_type          queue_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   item_type          new_item;
   logic              push, pop;

   always_comb begin
      unique case (req_tuser)
         OP_ADD:    new_item.kind = KIND_ADD;
         OP_TICK:   new_item.kind = KIND_TICK;
         OP_REWIND: new_item.kind = KIND_REWIND;
         default:   new_item.kind = KIND_NOP;
      endcase
      new_item.time_step = req_tdata[23:0];
      new_item.key_time  = req_tdata[55:24];
      for (int j = 0; j < CoordCount; j++) begin
         new_item.coord[j] = req_tdata[56 + 32*j +: 32];
      end
      new_item.easing = req_tdata[250:248];
   end

   assign req_tready = (count_ff != CntW'(QueueDepth));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == CntW'(QueueDepth)) |-> !req_tready)
      else $error("queue full but still ready");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CntW'(QueueDepth)))
      else $error("queue count out of range");

endmodule

// ----- rtl/kpi_back.sv -----
// Back end: keyframe table, insertion by shifting, segment search, serial divide,
// easing and mixing, and the result register. Depends on kpi_pkg.
module kpi_back #(
   parameter int MAX_KEYS         = kpi_pkg::MaxKeysDefault,
   parameter int SINE_TABLE_DEPTH = kpi_pkg::SineDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              item_valid,
   output logic              item_ready,
   input  kpi_pkg::item_type item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [191:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser
);
   import kpi_pkg::*;

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int SW = $clog2(SINE_TABLE_DEPTH + 1);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_ADD_CMP = 13'b0000000000010,
      ST_ADD_PUT = 13'b0000000000100,
      ST_TK_CHK0 = 13'b0000000001000,
      ST_TK_CHKS = 13'b0000000010000,
      ST_TK_CMPN = 13'b0000000100000,
      ST_RW_SNAP = 13'b0000001000000,
      ST_DIV     = 13'b0000010000000,
      ST_EASE0   = 13'b0000100000000,
      ST_EASE1   = 13'b0001000000000,
      ST_EASE2   = 13'b0010000000000,
      ST_MIX     = 13'b0100000000000,
      ST_DONE    = 13'b1000000000000
   } state_type;

   logic [16:0] sine_rom [SINE_TABLE_DEPTH + 1];
   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
      localparam logic [63:0] Angle = (64'd3373259426 * g) / (2 * SINE_TABLE_DEPTH);
      localparam logic [16:0] Value = sine_from_angle(Angle);
      assign sine_rom[g] = Value;
   end

   key_rec_type key_mem [MAX_KEYS];
   key_rec_type rd_ff;
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   key_rec_type mem_wd;

   state_type   state_ff, state_in;
   logic        playing_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [AW-1:0] seg_ff, seg_in;
   logic [CoordCount-1:0][31:0] pose_ff, pose_in;
   logic        changed_ff, changed_in;
   logic        full_drop_ff;
   item_type    item_ff, item_in;
   logic [AW-1:0] idx_ff, idx_in;
   key_rec_type rec_s_ff, rec_s_in, rec_e_ff, rec_e_in;
   logic [31:0] rem_ff, rem_in, div_ff, div_in;
   logic [15:0] q_ff, q_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   logic [2:0]  j_ff, j_in;
   logic [16:0] u_ff, u_in, e_ff, e_in, sin_ff;
   logic [SW-1:0] sidx_ff, sidx_in;
   logic [33:0] sq_ff, sq_in;
   logic [50:0] cube_ff, cube_in;
   logic        rsp_valid_ff;
   logic [191:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic        rsp_load;
   logic [1:0]  status;

   logic [32:0] el_sum;
   logic [CW-1:0] last;
   logic [AW-1:0] seg_eff;
   logic [31:0] delta;
   logic [32:0] rem2;
   logic [16:0] phase;
   logic [29:0] sprod;
   logic [29:0] sidx_wide;
   logic signed [32:0] diff;
   logic signed [50:0] prod;

   assign item_ready = (state_ff == ST_IDLE);
   assign last       = count_ff - 1'b1;
   assign el_sum     = {1'b0, elapsed_ff} + {9'd0, item_ff.time_step};
   assign rem2       = {rem_ff, 1'b0};
   assign sprod      = 30'(phase) * 30'(SINE_TABLE_DEPTH);
   assign sidx_wide  = (sprod + 30'd32768) >> 16;
   assign diff       = $signed({rec_e_ff.coord[j_ff][31], rec_e_ff.coord[j_ff]})
                     - $signed({rec_s_ff.coord[j_ff][31], rec_s_ff.coord[j_ff]});
   assign prod       = 51'(diff) * 51'($signed({1'b0, e_ff}));

   always_comb begin
      unique case (rec_e_ff.mode)
         EASE_SINE_IN:    phase = ONE_Q16 - {1'b0, q_ff};
         EASE_SINE_INOUT: phase = (q_ff < HALF_Q16) ? ONE_Q16 - {q_ff, 1'b0}
                                                    : {q_ff, 1'b0} - ONE_Q16;
         default:         phase = {1'b0, q_ff};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      seg_in     = seg_ff;
      pose_in    = pose_ff;
      item_in    = item_ff;
      idx_in     = idx_ff;
      rec_s_in   = rec_s_ff;
      rec_e_in   = rec_e_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      q_in       = q_ff;
      div_cnt_in = div_cnt_ff;
      j_in       = j_ff;
      u_in       = u_ff;
      e_in       = e_ff;
      sidx_in    = sidx_ff;
      sq_in      = sq_ff;
      cube_in    = cube_ff;
      mem_we     = 1'b0;
      mem_wa     = idx_ff;
      mem_wd     = rd_ff;
      mem_ra     = '0;
      rsp_load   = 1'b0;
      seg_eff    = (CW'(seg_ff) > last) ? last[AW-1:0] : seg_ff;
      delta      = rd_ff.key_time - rec_s_ff.key_time;
      status     = STATUS_UNCHANGED;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in = item;
               unique case (item.kind)
                  KIND_ADD: begin
                     if (count_ff >= CW'(MAX_KEYS)) begin
                        state_in = ST_DONE;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = ST_ADD_PUT;
                     end else begin
                        idx_in   = count_ff[AW-1:0];
                        mem_ra   = AW'(count_ff - 1'b1);
                        state_in = ST_ADD_CMP;
                     end
                  end
                  KIND_TICK: begin
                     if (!playing_ff || count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_TK_CHK0;
                     end
                  end
                  KIND_REWIND: begin
                     elapsed_in = '0;
                     seg_in     = '0;
                     state_in   = (count_ff == '0) ? ST_DONE : ST_RW_SNAP;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_CMP: begin
            if (rd_ff.key_time > item_ff.key_time) begin
               mem_we = 1'b1;
               mem_wd = rd_ff;
               idx_in = idx_ff - 1'b1;
               if (idx_ff == AW'(1)) begin
                  state_in = ST_ADD_PUT;
               end else begin
                  mem_ra = idx_ff - AW'(2);
               end
            end else begin
               state_in = ST_ADD_PUT;
            end
         end
         ST_ADD_PUT: begin
            mem_we          = 1'b1;
            mem_wd.mode     = item_ff.easing;
            mem_wd.key_time = item_ff.key_time;
            mem_wd.coord    = item_ff.coord;
            count_in        = count_ff + 1'b1;
            state_in        = ST_DONE;
         end
         ST_TK_CHK0: begin
            elapsed_in = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
            rec_s_in   = rd_ff;
            seg_in     = seg_eff;
            mem_ra     = seg_eff;
            if (elapsed_in <= rd_ff.key_time) begin
               pose_in  = rd_ff.coord;
               state_in = ST_DONE;
            end else if (count_ff < CW'(2)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_TK_CHKS;
            end
         end
         ST_TK_CHKS: begin
            if (elapsed_ff < rd_ff.key_time) begin
               elapsed_in = '0;
               seg_in     = '0;
               pose_in    = rec_s_ff.coord;
               state_in   = ST_DONE;
            end else if (CW'(seg_ff) >= last) begin
               pose_in  = rd_ff.coord;
               state_in = ST_DONE;
            end else begin
               rec_s_in = rd_ff;
               mem_ra   = seg_ff + 1'b1;
               state_in = ST_TK_CMPN;
            end
         end
         ST_TK_CMPN: begin
            if (elapsed_ff >= rd_ff.key_time) begin
               seg_in = seg_ff + 1'b1;
               if (CW'(seg_ff) + 1'b1 == last) begin
                  pose_in  = rd_ff.coord;
                  state_in = ST_DONE;
               end else begin
                  rec_s_in = rd_ff;
                  mem_ra   = seg_ff + AW'(2);
               end
            end else if (delta == '0) begin
               pose_in[2:0] = rd_ff.coord[2:0];
               state_in     = ST_DONE;
            end else begin
               rec_e_in   = rd_ff;
               div_in     = delta;
               rem_in     = elapsed_ff - rec_s_ff.key_time;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_RW_SNAP: begin
            pose_in  = rd_ff.coord;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (rem2 >= {1'b0, div_ff}) begin
               rem_in = 32'(rem2 - {1'b0, div_ff});
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = rem2[31:0];
               q_in   = {q_ff[14:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 4'd15) begin
               state_in = ST_EASE0;
            end
         end
         ST_EASE0: begin
            sidx_in = (sidx_wide > 30'(SINE_TABLE_DEPTH)) ? SW'(SINE_TABLE_DEPTH)
                                                          : sidx_wide[SW-1:0];
            unique case (rec_e_ff.mode)
               EASE_CUBIC_OUT:   u_in = ONE_Q16 - {1'b0, q_ff};
               EASE_CUBIC_INOUT: u_in = (q_ff < HALF_Q16) ? {1'b0, q_ff}
                                                         : 17'(18'd131072 - {1'b0, q_ff, 1'b0});
               default:          u_in = {1'b0, q_ff};
            endcase
            sq_in    = 34'(u_in) * 34'(u_in);
            state_in = ST_EASE1;
         end
         ST_EASE1: begin
            cube_in  = 51'(sq_ff) * 51'(u_ff);
            state_in = ST_EASE2;
         end
         ST_EASE2: begin
            unique case (rec_e_ff.mode)
               EASE_SINE_IN:    e_in = ONE_Q16 - sin_ff;
               EASE_SINE_OUT:   e_in = sin_ff;
               EASE_SINE_INOUT: e_in = (q_ff < HALF_Q16) ? 17'((ONE_Q16 - sin_ff) >> 1)
                                                        : 17'(({1'b0, ONE_Q16} + {1'b0, sin_ff}) >> 1);
               EASE_CUBIC_IN:   e_in = 17'(cube_ff >> 32);
               EASE_CUBIC_OUT:  e_in = ONE_Q16 - 17'(cube_ff >> 32);
               EASE_CUBIC_INOUT: e_in = (q_ff < HALF_Q16) ? 17'(cube_ff >> 30)
                                                         : ONE_Q16 - 17'(cube_ff >> 33);
               default:         e_in = {1'b0, q_ff};
            endcase
            j_in     = '0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            pose_in[j_ff] = rec_s_ff.coord[j_ff] + prod[47:16];
            j_in          = j_ff + 1'b1;
            if (j_ff == 3'(CoordCount - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            unique case (item_ff.kind)
               KIND_ADD:    status = full_drop_ff ? STATUS_FULL : STATUS_STORED;
               KIND_TICK,
               KIND_REWIND: status = changed_ff ? STATUS_MOVED : STATUS_UNCHANGED;
               default:     status = STATUS_UNCHANGED;
            endcase
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      changed_in = (state_ff == ST_IDLE) ? 1'b0 : (changed_ff || (pose_in != pose_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         count_ff     <= '0;
         elapsed_ff   <= '0;
         seg_ff       <= '0;
         pose_ff      <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         full_drop_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         seg_ff     <= seg_in;
         pose_ff    <= pose_in;
         changed_ff <= changed_in;
         if (csr_wr_en) begin
            playing_ff <= csr_wr_data;
         end
         if (state_ff == ST_IDLE && item_valid) begin
            full_drop_ff <= (item.kind == KIND_ADD) && (count_ff >= CW'(MAX_KEYS));
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      rec_s_ff   <= rec_s_in;
      rec_e_ff   <= rec_e_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      q_ff       <= q_in;
      div_cnt_ff <= div_cnt_in;
      j_ff       <= j_in;
      u_ff       <= u_in;
      e_ff       <= e_in;
      sidx_ff    <= sidx_in;
      sq_ff      <= sq_in;
      cube_ff    <= cube_in;
      sin_ff     <= sine_rom[sidx_ff];
      if (rsp_load) begin
         rsp_data_ff <= pose_ff;
         rsp_user_ff <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= key_mem[mem_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS))
      else $error("key count beyond table size");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (CW'(seg_ff) < count_ff))
      else $error("segment index beyond last key");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("key count changed by other than one");

endmodule

// ----- rtl/keyframe_path_interpolator.sv -----
// Top level of the keyframe path interpolator: front queue plus back sequencer.
// Depends on kpi_pkg, kpi_front and kpi_back.
//
// Requests arrive on req_tvalid/req_tready; req_tuser carries the opcode (add key,
// tick, rewind) and req_tdata the key and tick fields. Every request yields exactly
// one transfer on rsp_*, in order: rsp_tuser is the status, rsp_tdata the pose.
// csr_wr_en writes the playing flag from csr_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. A two-entry queue
// takes requests while the back end works, so the request side only stalls when the
// queue is full. An add shifts the table memory one key per cycle to make room for
// the new key. A tick either snaps to a key or interpolates: the bit-serial divider
// forms a 16-bit fraction, then the easing states ST_EASE0 to ST_EASE2 shape it, and
// the six coordinates are mixed in turn through one shared multiplier.
// The back end holds a finished result in the output register until it is taken;
// a stalled receiver therefore stops the back end, then fills the queue.
// Reset clears the key count, elapsed time, segment index, pose and playing flag;
// the key table needs no clearing as entries are read only below the count.
module keyframe_path_interpolator #(
   parameter int MAX_KEYS         = kpi_pkg::MaxKeysDefault,
   parameter int SINE_TABLE_DEPTH = kpi_pkg::SineDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: time_step, key_time, key_pos_x/y/z, key_target_x/y/z, key_easing.
   input  logic [255:0] req_tdata,
   // Fields from bit 0: opcode.
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: out_pos_x/y/z, out_target_x/y/z.
   output logic [191:0] rsp_tdata,
   // Fields from bit 0: status.
   output logic [1:0]   rsp_tuser
);
   import kpi_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_ready;

   kpi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   kpi_back #(
      .MAX_KEYS         (MAX_KEYS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- tb/sv/tb_keyframe_path_interpolator.sv -----
// Self-checking testbench for the keyframe path interpolator: keyframe insertion,
// ticks with seven easing curves, rewinds and table overflow against a local predictor.
// Depends on kpi_pkg and keyframe_path_interpolator.
module tb_keyframe_path_interpolator;
   timeunit 1ns;
   timeprecision 1ps;
   import kpi_pkg::*;

   localparam int NumKeys   = 16;
   localparam int SineDepth = 256;
   localparam int CycleLimit = 2000000;
   localparam logic [1:0] OpUndefined   = 2'd3;
   localparam logic [2:0] EaseLinear    = 3'd0;
   localparam logic [2:0] EaseUndefined = 3'd7;

   typedef struct packed {
      logic [1:0]   status;
      logic [191:0] pose;
   } pose_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  hold_off_cycles = 0;
   int unsigned  cycle_count = 0;
   int unsigned  mismatch_count = 0;

   pose_result_type expected_poses[$];

   // Predictor state.
   logic [31:0]        sine_lut[SineDepth+1];
   logic [31:0]        p_times[NumKeys];
   logic signed [31:0] p_coords[NumKeys][6];
   logic [2:0]         p_modes[NumKeys];
   int unsigned        p_count;
   logic [31:0]        p_elapsed;
   int unsigned        p_segment;
   logic signed [31:0] p_pose[6];
   logic               p_playing;

   keyframe_path_interpolator dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [31:0] sine_entry(input int unsigned i);
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [66:0] sum;
      logic [66:0]        r;
      a = (64'd3373259426 * 64'(i)) / 64'(2 * SineDepth);
      a2 = (a * a) >> 30;
      term = a;
      sum = $signed({3'b000, a});
      for (int k = 1; k <= 6; k++) begin
         term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - $signed({3'b000, term});
         else sum = sum + $signed({3'b000, term});
      end
      if (sum < 0) sum = '0;
      r = ($unsigned(sum) + 67'd8192) >> 14;
      if (r > 67'd65536) r = 67'd65536;
      return 32'(r);
   endfunction

   function automatic logic [31:0] quarter_sine(input logic [31:0] phase);
      logic [63:0] idx;
      logic [31:0] p;
      p = (phase > 32'd65536) ? 32'd65536 : phase;
      idx = (64'(p) * SineDepth + 64'd32768) >> 16;
      if (idx > SineDepth) idx = SineDepth;
      return sine_lut[idx];
   endfunction

   function automatic logic [31:0] eased_fraction(input logic [31:0] t_in,
                                                  input logic [2:0] mode);
      logic [63:0] u;
      logic [31:0] t;
      t = (t_in > 32'd65536) ? 32'd65536 : t_in;
      case (mode)
         EASE_SINE_IN:  return 32'd65536 - quarter_sine(32'd65536 - t);
         EASE_SINE_OUT: return quarter_sine(t);
         EASE_SINE_INOUT: begin
            if (t < 32'd32768) return (32'd65536 - quarter_sine(32'd65536 - 2 * t)) >> 1;
            return (32'd65536 + quarter_sine(2 * t - 32'd65536)) >> 1;
         end
         EASE_CUBIC_IN: return 32'((64'(t) * t * t) >> 32);
         EASE_CUBIC_OUT: begin
            u = 64'd65536 - t;
            return 32'd65536 - 32'((u * u * u) >> 32);
         end
         EASE_CUBIC_INOUT: begin
            if (t < 32'd32768) return 32'((64'(t) * t * t) >> 30);
            u = 64'd131072 - 2 * 64'(t);
            return 32'd65536 - 32'((u * u * u) >> 33);
         end
         default: return t;
      endcase
   endfunction

   function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [31:0] e);
      logic signed [127:0] prod;
      logic signed [127:0] q;
      prod = (128'(b) - 128'(a)) * $signed({96'd0, e});
      if (prod < 0) q = -((-prod + 65535) >>> 16);
      else q = prod >>> 16;
      return 32'(128'(a) + q);
   endfunction

   function automatic void snap_to_key(input int unsigned k);
      for (int j = 0; j < 6; j++) p_pose[j] = p_coords[k][j];
   endfunction

   function automatic void advance_playback(input logic [23:0] dt);
      logic [32:0] sum;
      int unsigned last;
      logic [31:0] delta;
      logic [31:0] t;
      int unsigned s;
      if (!p_playing || p_count == 0) return;
      sum = 33'(p_elapsed) + 33'(dt);
      p_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (p_elapsed <= p_times[0]) begin
         snap_to_key(0);
         return;
      end
      if (p_count < 2) return;
      last = p_count - 1;
      if (p_segment > last) p_segment = last;
      if (p_elapsed < p_times[p_segment]) begin
         p_elapsed = '0;
         p_segment = 0;
         snap_to_key(0);
         return;
      end
      while (p_segment < last && p_elapsed >= p_times[p_segment+1]) p_segment++;
      if (p_segment >= last) begin
         snap_to_key(last);
         return;
      end
      s = p_segment;
      delta = p_times[s+1] - p_times[s];
      if (delta == 0) begin
         for (int j = 0; j < 3; j++) p_pose[j] = p_coords[s+1][j];
         return;
      end
      t = 32'(({32'd0, p_elapsed - p_times[s]} << 16) / 64'(delta));
      t = eased_fraction(t, p_modes[s+1]);
      for (int j = 0; j < 6; j++) p_pose[j] = blend(p_coords[s][j], p_coords[s+1][j], t);
   endfunction

   function automatic pose_result_type predict_pose(input logic [1:0] op,
                                                    input logic [255:0] d);
      pose_result_type r;
      logic signed [31:0] prior[6];
      int unsigned pos;
      logic changed;
      prior = p_pose;
      r.status = STATUS_UNCHANGED;
      if (op == OP_ADD) begin
         if (p_count >= NumKeys) begin
            r.status = STATUS_FULL;
         end else begin
            pos = p_count;
            while (pos > 0 && p_times[pos-1] > d[55:24]) pos--;
            for (int i = p_count; i > pos; i--) begin
               p_times[i] = p_times[i-1];
               p_modes[i] = p_modes[i-1];
               p_coords[i] = p_coords[i-1];
            end
            p_times[pos] = d[55:24];
            p_modes[pos] = d[250:248];
            for (int j = 0; j < 6; j++) p_coords[pos][j] = d[56+32*j +: 32];
            p_count++;
            r.status = STATUS_STORED;
         end
      end else if (op == OP_TICK || op == OP_REWIND) begin
         if (op == OP_TICK) begin
            advance_playback(d[23:0]);
         end else begin
            p_elapsed = '0;
            p_segment = 0;
            if (p_count > 0) snap_to_key(0);
         end
         changed = 1'b0;
         for (int j = 0; j < 6; j++) if (prior[j] != p_pose[j]) changed = 1'b1;
         r.status = changed ? STATUS_MOVED : STATUS_UNCHANGED;
      end
      for (int j = 0; j < 6; j++) r.pose[32*j +: 32] = p_pose[j];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [191:0] got,
                                  input logic [191:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pose_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_poses.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, '0);
         end else begin
            want = expected_poses.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", 192'(rsp_tuser), 192'(want.status));
            for (int j = 0; j < 6; j++)
               if (rsp_tdata[32*j +: 32] !== want.pose[32*j +: 32])
                  report_mismatch($sformatf("pose field %0d", j),
                                  192'(rsp_tdata[32*j +: 32]), 192'(want.pose[32*j +: 32]));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [255:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      expected_poses = {expected_poses, predict_pose(op, d)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [255:0] key_item(input logic [31:0] kt, input logic [2:0] mode,
                                             input logic signed [31:0] c0);
      logic [255:0] d;
      d = '0;
      d[23:0] = 24'($urandom);
      d[55:24] = kt;
      d[56 +: 32] = c0;
      for (int j = 1; j < 6; j++) d[56+32*j +: 32] = $urandom;
      d[250:248] = mode;
      return d;
   endfunction

   function automatic logic [255:0] tick_item(input logic [23:0] dt);
      logic [255:0] d;
      d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      d[255:251] = '0;
      d[23:0] = dt;
      return d;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_playing(input logic value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      p_playing = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic clear_table();
      // The table can only be emptied by reset, so phases refill from a rewound state.
      send_item(OP_REWIND, tick_item(24'd0));
   endtask

   task automatic test_directed();
      send_item(OP_TICK, tick_item(24'hFFFFFF));
      send_item(OP_REWIND, tick_item(24'd0));
      send_item(OpUndefined, tick_item(24'h123456));
      write_playing(1'b1);
      send_item(OP_TICK, tick_item(24'd100));
      send_item(OP_ADD, key_item(32'h0002_0000, EaseLinear, 32'sh7FFF_FFFF));
      send_item(OP_TICK, tick_item(24'h01_0000));
      send_item(OP_TICK, tick_item(24'h02_0000));
      send_item(OP_ADD, key_item(32'h0000_8000, EaseUndefined, 32'sh8000_0000));
      send_item(OP_ADD, key_item(32'h0002_0000, EASE_SINE_IN, 32'sd0));
      send_item(OP_ADD, key_item(32'h0004_0000, EASE_SINE_OUT, 32'sh8000_0000));
      send_item(OP_ADD, key_item(32'h0006_0000, EASE_SINE_INOUT, 32'sh7FFF_FFFF));
      send_item(OP_ADD, key_item(32'h0008_0000, EASE_CUBIC_IN, 32'sd5));
      send_item(OP_ADD, key_item(32'h000A_0000, EASE_CUBIC_OUT, -32'sd5));
      send_item(OP_ADD, key_item(32'hFFFF_FFFF, EASE_CUBIC_INOUT, 32'sd1));
      send_item(OP_REWIND, tick_item(24'd0));
      for (int i = 0; i < 12; i++) send_item(OP_TICK, tick_item(24'h00_C000));
      send_item(OP_ADD, key_item(32'h0000_0001, EaseLinear, 32'sd9));
      send_item(OP_TICK, tick_item(24'hFF_FFFF));
      send_item(OP_REWIND, tick_item(24'd0));
   endtask

   task automatic test_random(input int unsigned count);
      int unsigned pick;
      logic [31:0] kt;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            kt = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20)) << 15;
            send_item(OP_ADD, key_item(kt, 3'($urandom), $urandom));
         end else if (pick < 85) begin
            send_item(OP_TICK, tick_item(($urandom_range(15) == 0) ?
                                         24'($urandom) : 24'($urandom_range(24'h1_0000))));
         end else if (pick < 95) begin
            send_item(OP_REWIND, tick_item(24'($urandom)));
         end else begin
            send_item(OpUndefined, tick_item(24'($urandom)));
         end
      end
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 300;
      for (int i = 0; i < 8; i++) send_item(OP_TICK, tick_item(24'h00_4000));
      drain();
      send_item(OP_REWIND, tick_item(24'd0));
   endtask

   initial begin
      for (int i = 0; i <= SineDepth; i++) sine_lut[i] = sine_entry(i);
      p_count = 0;
      p_elapsed = '0;
      p_segment = 0;
      p_playing = 1'b0;
      for (int j = 0; j < 6; j++) p_pose[j] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 59;
      test_directed();
      test_random(300);
      write_playing(1'b0);
      test_random(40);
      write_playing(1'b1);
      send_idle_pct = 59;
      recv_idle_pct = 11;
      test_backpressure();
      test_random(300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      clear_table();
      test_random(280);
      drain();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/kpi_pkg.sv
rtl/kpi_front.sv
rtl/kpi_back.sv
rtl/keyframe_path_interpolator.sv
tb/sv/tb_keyframe_path_interpolator.sv
